>>> hdl/iad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iad_pkg;

    // Field widths of the input and result words.
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int START_W  = 8;
    localparam int STEP_W   = 15;
    localparam int CODE_W   = 4;
    localparam int MAG_W    = 3;

    // Step index range and predictor limits.
    localparam int IDX_MAX    = 88;
    localparam int SAMPLE_MAX = 32767;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Operation codes of an input word.
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic                       is_data;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         index;
        logic [BYTE_W-1:0]          data;
    } t_cmd;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // Step size table, indexed by the step index.
    function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Index adjustment, looked up on the code magnitude.
    function automatic logic signed [4:0] index_adjust(input logic [MAG_W-1:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hdl/iad_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: block headers and data bytes.
interface iad_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] first_sample;
    logic [7:0]  start_index;
    logic [7:0]  data_byte;

    modport source (output valid, output op, output first_sample, output start_index,
                    output data_byte, input ready);
    modport sink   (input valid, input op, input first_sample, input start_index,
                    input data_byte, output ready);
endinterface

// Result channel: decoded samples.
interface iad_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/iad_front.sv
`timescale 1ns / 1ps
`default_nettype none

module iad_front
    import iad_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    iad_in_if.sink i_in,
    input  wire    i_pop,
    output t_head  o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the incoming word and saturate the header index.
    always_comb begin
        w_cmd.is_data = (i_in.op == OP_DATA);
        w_cmd.sample  = $signed(i_in.first_sample);
        if (i_in.start_index > START_W'(IDX_MAX)) begin
            w_cmd.index = INDEX_W'(IDX_MAX);
        end else begin
            w_cmd.index = i_in.start_index[INDEX_W-1:0];
        end
        w_cmd.data = i_in.data_byte;
    end

    assign i_in.ready = (r_count != CNT_FULL);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

endmodule

`default_nettype wire

>>> hdl/iad_back.sv
`timescale 1ns / 1ps
`default_nettype none

module iad_back
    import iad_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_head     i_head,
    output logic      o_pop,
    iad_out_if.source o_out
);

    localparam int SUM_W  = SAMPLE_W + 3;
    localparam int MUL_W  = STEP_W + MAG_W;
    localparam int DIFF_W = STEP_W + 2;

    logic signed [SAMPLE_W-1:0] r_pred;
    logic [INDEX_W-1:0]         r_idx;
    logic                       r_hi_pending;
    logic [CODE_W-1:0]          r_hi_code;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_sample;
    logic                       r_last;

    logic                       w_advance;
    logic [CODE_W-1:0]          w_code;
    logic [MAG_W-1:0]           w_mag;
    logic [STEP_W-1:0]          w_step;
    logic [MUL_W-1:0]           w_mul;
    logic [DIFF_W-1:0]          w_diff;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SAMPLE_W-1:0] w_new_pred;
    logic signed [INDEX_W:0]    w_idx_sum;
    logic [INDEX_W-1:0]         w_new_idx;

    // A new result may be formed when the output word is empty or being taken.
    assign w_advance = !r_out_valid || o_out.ready;
    assign o_pop     = w_advance && !r_hi_pending && i_head.valid;

    // Decode one code from the current predictor and step index.
    always_comb begin
        w_code = r_hi_pending ? r_hi_code : i_head.cmd.data[CODE_W-1:0];
        w_mag  = w_code[MAG_W-1:0];
        w_step = step_lookup(r_idx);
        w_mul  = (w_mag[0] ? MUL_W'(w_step) : '0)
               + (w_mag[1] ? (MUL_W'(w_step) << 1) : '0)
               + (w_mag[2] ? (MUL_W'(w_step) << 2) : '0);
        w_diff = DIFF_W'(w_mul >> 2) + DIFF_W'(w_step >> 3);
        if (w_code[CODE_W-1]) begin
            w_sum = SUM_W'(r_pred) - $signed({2'b00, w_diff});
        end else begin
            w_sum = SUM_W'(r_pred) + $signed({2'b00, w_diff});
        end
        if (w_sum > SUM_W'(SAMPLE_MAX)) begin
            w_new_pred = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_sum < -SUM_W'(SAMPLE_MAX)) begin
            w_new_pred = -SAMPLE_W'(SAMPLE_MAX);
        end else begin
            w_new_pred = w_sum[SAMPLE_W-1:0];
        end
        w_idx_sum = $signed({1'b0, r_idx}) + (INDEX_W+1)'(index_adjust(w_mag));
        if (w_idx_sum < 0) begin
            w_new_idx = '0;
        end else if (w_idx_sum > (INDEX_W+1)'(IDX_MAX)) begin
            w_new_idx = INDEX_W'(IDX_MAX);
        end else begin
            w_new_idx = w_idx_sum[INDEX_W-1:0];
        end
    end

    // Decoder state and output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred       <= '0;
            r_idx        <= '0;
            r_hi_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (w_advance) begin
            if (r_hi_pending) begin
                r_pred       <= w_new_pred;
                r_idx        <= w_new_idx;
                r_hi_pending <= 1'b0;
                r_out_valid  <= 1'b1;
                r_sample     <= w_new_pred;
                r_last       <= 1'b1;
            end else if (i_head.valid) begin
                r_out_valid <= 1'b1;
                if (i_head.cmd.is_data) begin
                    r_pred       <= w_new_pred;
                    r_idx        <= w_new_idx;
                    r_hi_pending <= 1'b1;
                    r_hi_code    <= i_head.cmd.data[BYTE_W-1:CODE_W];
                    r_sample     <= w_new_pred;
                    r_last       <= 1'b0;
                end else begin
                    r_pred   <= i_head.cmd.sample;
                    r_idx    <= i_head.cmd.index;
                    r_sample <= i_head.cmd.sample;
                    r_last   <= 1'b1;
                end
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;
    assign o_out.last   = r_last;

endmodule

`default_nettype wire

>>> hdl/ima_adpcm_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Mono 4-bit IMA ADPCM block decoder. A header word (op 0) loads the predictor
// and step index and returns its sample as one word with last set; a data word
// (op 1) returns two samples, low nibble first, the second with last set. The
// front end queues classified input words while the back end decodes, so input
// keeps flowing while a result waits on the output register. The decode unit
// produces one sample per cycle while the output is empty or being taken; the
// nibbles of a data byte are serially dependent through the predictor and index.

module ima_adpcm_block_decoder
    import iad_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    iad_in_if.sink    i_in,
    iad_out_if.source o_out
);

    t_head w_head;
    logic  w_pop;

    // Front end: accept and classify input words into the queue.
    iad_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back end: decode queued commands into samples.
    iad_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
